// ===== hw/rtl/lspbe_pkg.sv =====
package lspbe_pkg;

	// Bit slots per LED: green, red, blue bytes, most significant bit first
	localparam int SLOTS_PER_LED = 24;
	localparam int RESET_SLOTS_DEF = 40;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

	// Register index, taken from paddr[2]
	localparam logic REG_TIMER_PERIOD = 1'b0;

	// Short time = period * 7 / 25. The product fits in 19 bits, and
	// ceil(2^24 / 25) gives an exact quotient over that whole range.
	localparam int TIMES7_W = PERIOD_W + 3;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W = 20;
	localparam logic [RECIP_W-1:0] RECIP = 20'd671089;
	localparam int PROD_W = TIMES7_W + RECIP_W;
	localparam logic [PROD_W-1:0] PROD_RESET =
		PROD_W'(longint'(PERIOD_RESET) * 64'd7 * longint'(RECIP));

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_led;
	} led_in_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] compare_value;
		logic                run_last;
		logic                in_gap;
	} led_out_t;

	// One queued LED: the 24 slot bits in send order plus the frame end mark
	typedef struct packed {
		logic                     last_led;
		logic [SLOTS_PER_LED-1:0] bits;
	} job_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] short_cnt;
		logic [PERIOD_W-1:0] long_cnt;
	} high_times_t;

endpackage

// ===== hw/rtl/lspbe_cfg.sv =====
module lspbe_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lspbe_pkg::ADDR_W-1:0] paddr,
	input  logic [lspbe_pkg::DATA_W-1:0] pwdata,
	output logic [lspbe_pkg::DATA_W-1:0] prdata,
	output logic                         pready,
	output lspbe_pkg::high_times_t       times
);
	import lspbe_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	logic [PROD_W-1:0]   prod_q;
	logic [TIMES7_W-1:0] times7;
	logic [PERIOD_W-1:0] short_cnt;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMER_PERIOD);

	// period * 7 as shift and subtract, ahead of the reciprocal multiply
	assign times7 = {pwdata[PERIOD_W-1:0], 3'b000} - {3'b000, pwdata[PERIOD_W-1:0]};

	// Register the period and its scaled product on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			prod_q   <= PROD_RESET;
		end else if (wr_en) begin
			period_q <= pwdata[PERIOD_W-1:0];
			prod_q   <= PROD_W'(times7) * PROD_W'(RECIP);
		end
	end

	assign short_cnt       = PERIOD_W'(prod_q[PROD_W-1:RECIP_SHIFT]);
	assign times.short_cnt = short_cnt;
	assign times.long_cnt  = period_q - short_cnt;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TIMER_PERIOD) begin
			prdata = DATA_W'(period_q);
		end
	end

endmodule

// ===== hw/rtl/lspbe_queue.sv =====
module lspbe_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lspbe_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output lspbe_pkg::job_t head
);
	import lspbe_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

// ===== hw/rtl/lspbe_back.sv =====
module lspbe_back #(
	parameter int RESET_SLOTS = lspbe_pkg::RESET_SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  lspbe_pkg::job_t        q_head,
	output logic                   q_pop,
	input  lspbe_pkg::high_times_t times,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lspbe_pkg::led_out_t    out_item
);
	import lspbe_pkg::*;

	localparam int TOTAL_MAX = SLOTS_PER_LED + RESET_SLOTS;
	localparam int CNT_W = $clog2(TOTAL_MAX);
	localparam logic [CNT_W-1:0] END_PLAIN = CNT_W'(SLOTS_PER_LED - 1);
	localparam logic [CNT_W-1:0] END_GAP   = CNT_W'(TOTAL_MAX - 1);
	localparam logic [CNT_W-1:0] GAP_START = CNT_W'(SLOTS_PER_LED);

	logic                     cur_valid_q;
	logic                     cur_last_q;
	logic [SLOTS_PER_LED-1:0] bits_q;
	logic [CNT_W-1:0]         slot_q;
	logic                     out_valid_q;
	led_out_t                 out_q;

	logic [CNT_W-1:0] end_idx;
	logic             at_end;
	logic             advance;
	logic             take;
	led_out_t         result;

	assign end_idx = cur_last_q ? END_GAP : END_PLAIN;
	assign at_end  = (slot_q == end_idx);
	assign advance = cur_valid_q && (!out_valid_q || !out_stall);
	assign take    = !q_empty && (!cur_valid_q || (advance && at_end));
	assign q_pop   = take;

	always_comb begin
		result.in_gap   = (slot_q >= GAP_START);
		result.run_last = at_end;
		if (result.in_gap) begin
			result.compare_value = '0;
		end else begin
			result.compare_value = bits_q[SLOTS_PER_LED-1] ? times.long_cnt : times.short_cnt;
		end
	end

	// Current LED: slot counter and shifting bit word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_last_q  <= 1'b0;
			slot_q      <= '0;
		end else if (take) begin
			cur_valid_q <= 1'b1;
			cur_last_q  <= q_head.last_led;
			slot_q      <= '0;
		end else if (advance) begin
			if (at_end) begin
				cur_valid_q <= 1'b0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bits_q <= q_head.bits;
		end else if (advance) begin
			bits_q <= {bits_q[SLOTS_PER_LED-2:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> slot_q <= end_idx)
		else $error("slot counter past end of LED");

	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.in_gap |-> out_q.compare_value == '0)
		else $error("non-zero compare value in latch gap");

endmodule

// ===== hw/rtl/led_strip_pwm_bit_encoder.sv =====
// LED strip PWM bit encoder.
// Input channel (in_valid / in_stall / in_item) takes one LED colour per item.
// Output channel (out_valid / out_stall / out_item) gives one timer compare
// value per bit slot: green, red, blue, most significant bit first. A one bit
// gives the long high time, a zero bit the short one (period * 7 / 25). An LED
// marked last_led is followed by RESET_SLOTS zero slots flagged in_gap; run_last
// marks the final slot of each item.
// Throughput: one result per cycle unless the receiver stalls or the queue is
// empty; an LED gives 24 slots, 24 + RESET_SLOTS for the last LED of a frame,
// counted by the slot counter in the back end. An accepted item reaches the
// output through the queue, the slot register and the output register.
// A two-entry queue parts the front from the back: the input keeps taking
// items while the back end works or the receiver stalls; in_stall rises only
// when the queue is full. A stalled result holds in the output register.
// The APB port holds timer_period at byte address 0 (reset 104); both high
// times take effect at the edge that writes the period. Reset empties the queue
// and the output register and restores the period; no clearing pass is needed.
module led_strip_pwm_bit_encoder #(
	parameter int RESET_SLOTS = lspbe_pkg::RESET_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  lspbe_pkg::led_in_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output lspbe_pkg::led_out_t          out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lspbe_pkg::ADDR_W-1:0] paddr,
	input  logic [lspbe_pkg::DATA_W-1:0] pwdata,
	output logic [lspbe_pkg::DATA_W-1:0] prdata,
	output logic                         pready
);
	import lspbe_pkg::*;

	high_times_t times;
	job_t        in_job;
	job_t        q_head;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;

	// Front: order the colour bytes into send order and queue the item
	assign in_job.bits     = {in_item.green, in_item.red, in_item.blue};
	assign in_job.last_led = in_item.last_led;
	assign in_stall        = q_full;

	lspbe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.times   (times)
	);

	lspbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid),
		.push_job (in_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// Back: walk the slots of one LED and drive the output register
	lspbe_back #(
		.RESET_SLOTS (RESET_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.times     (times),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lspbe_pkg::*;

	// Latch gap length, passed to the block so both sides agree
	localparam int GAP_SLOTS = 40;

	// Register byte addresses: the period, and a spare index the block must ignore
	localparam logic [ADDR_W-1:0] PERIOD_ADDR = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	// High times at the reset period of 104, read straight off the spec
	localparam logic [PERIOD_W-1:0] RESET_SHORT = 16'd29;
	localparam logic [PERIOD_W-1:0] RESET_LONG = 16'd75;

	localparam int PHASES = 8;
	localparam int LEDS_PER_PHASE = 45;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	// Directed rows: colour, frame end mark, and whether the high times are typed in
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
		logic       typed;
	} dir_row_t;

	localparam int DIR_COUNT = 16;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1},	// all zero bits: short time throughout
		'{8'hff, 8'hff, 8'hff, 1'b0, 1'b1},	// all one bits: long time throughout
		'{8'h00, 8'h00, 8'h00, 1'b1, 1'b1},	// frame end straight after frame end
		'{8'hff, 8'hff, 8'hff, 1'b1, 1'b1},
		'{8'h80, 8'h00, 8'h00, 1'b0, 1'b0},	// single bits locate each byte
		'{8'h00, 8'h80, 8'h00, 1'b0, 1'b0},
		'{8'h00, 8'h00, 8'h01, 1'b0, 1'b0},
		'{8'h00, 8'h01, 8'h80, 1'b0, 1'b0},
		'{8'haa, 8'h55, 8'haa, 1'b0, 1'b0},
		'{8'h55, 8'haa, 8'h55, 1'b1, 1'b0},
		'{8'hff, 8'h00, 8'h00, 1'b0, 1'b0},	// one byte full at a time
		'{8'h00, 8'hff, 8'h00, 1'b0, 1'b0},
		'{8'h00, 8'h00, 8'hff, 1'b1, 1'b0},
		'{8'h7f, 8'hfe, 8'h81, 1'b0, 1'b0},
		'{8'h01, 8'h80, 8'h00, 1'b1, 1'b0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	led_in_t in_item;
	logic out_valid;
	logic out_stall;
	led_out_t out_item;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Predictor state: the high times that follow from the last period written
	logic [PERIOD_W-1:0] short_time;
	logic [PERIOD_W-1:0] long_time;

	// Slots still owed by the block, oldest first
	led_out_t pending_slots[$];
	int mismatches = 0;
	int slots_taken = 0;

	// Sender burst bookkeeping
	int burst_left = 0;

	led_strip_pwm_bit_encoder #(
		.RESET_SLOTS(GAP_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Derive both high times from a period: short is period * 7 / 25, rounded down
	function automatic void set_period(input logic [PERIOD_W-1:0] period);
		int unsigned p;
		p = 32'(period);
		short_time = PERIOD_W'((p * 7) / 25);
		long_time = PERIOD_W'(p - ((p * 7) / 25));
	endfunction

	// Queue the slots one LED owes: green, red, blue, MSB first, then the gap if marked
	function automatic void queue_led_slots(input led_in_t led,
			input logic [PERIOD_W-1:0] t_short, input logic [PERIOD_W-1:0] t_long);
		logic [23:0] word;
		led_out_t slot;
		int total;
		word = {led.green, led.red, led.blue};
		total = SLOTS_PER_LED + (led.last_led ? GAP_SLOTS : 0);
		for (int k = 0; k < total; k++) begin
			if (k < SLOTS_PER_LED) begin
				slot.compare_value = word[23 - k] ? t_long : t_short;
				slot.in_gap = 1'b0;
			end else begin
				slot.compare_value = '0;
				slot.in_gap = 1'b1;
			end
			slot.run_last = (k == total - 1);
			pending_slots.push_back(slot);
		end
	endfunction

	// Byte with a bias toward the extremes
	function automatic logic [7:0] rand_byte();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		else if (pick == 1)
			return 8'hff;
		else
			return 8'($urandom);
	endfunction

	// Offer one LED and hold it until taken; then idle the sender between bursts
	task automatic send_led(input led_in_t led, input bit typed);
		int gap;
		in_item <= led;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (typed)
			queue_led_slots(led, RESET_SHORT, RESET_LONG);
		else
			queue_led_slots(led, short_time, long_time);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// Mostly short gaps, sometimes a long one so the block drains mid-frame
			case ($urandom_range(0, 7))
				0, 1, 2: gap = 0;
				3: gap = $urandom_range(20, 60);
				default: gap = $urandom_range(1, 4);
			endcase
			// Now and then a long burst with no idling at all
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Configuration write: setup cycle, then access until pready
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[2] == REG_TIMER_PERIOD)
			set_period(data[PERIOD_W-1:0]);
	endtask

	// Let every owed slot arrive, then allow for the block's pipeline to settle
	task automatic wait_drained();
		while (pending_slots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Compare every slot taken against the oldest one owed
	always @(posedge clk) begin
		led_out_t owed;
		if (arst_n && out_valid && !out_stall) begin
			slots_taken++;
			if (pending_slots.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected slot: compare %0d run_last %b in_gap %b",
						out_item.compare_value, out_item.run_last, out_item.in_gap);
			end else begin
				owed = pending_slots.pop_front();
				if (out_item.compare_value !== owed.compare_value
						|| out_item.run_last !== owed.run_last
						|| out_item.in_gap !== owed.in_gap) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"slot %0d: compare exp %0d got %0d, ",
							"run_last exp %b got %b, in_gap exp %b got %b"},
							slots_taken, owed.compare_value, out_item.compare_value,
							owed.run_last, out_item.run_last, owed.in_gap, out_item.in_gap);
				end
			end
		end
	end

	// Receiver: stall in stretches of varying character, and hold off for a long
	// spell twice while the sender keeps offering, so the queue fills and in_stall rises
	initial begin : receiver
		int mode;
		int span;
		int holds;
		int hold_at;
		out_stall <= 1'b0;
		holds = 0;
		hold_at = 300;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 80);
			repeat (span) begin
				@(posedge clk);
				if (holds < 2 && slots_taken >= hold_at) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					holds++;
					hold_at += 5000;
				end
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Main sequence: reset, directed rows, then random frames over several periods
	initial begin : stimulus
		led_in_t led;
		logic [PERIOD_W-1:0] period;
		int sent;
		int frame_len;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		set_period(PERIOD_RESET);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows run at the reset period, so typed rows can use 29 and 75
		for (int r = 0; r < DIR_COUNT; r++) begin
			led.red = DIR_ROWS[r].red;
			led.green = DIR_ROWS[r].green;
			led.blue = DIR_ROWS[r].blue;
			led.last_led = DIR_ROWS[r].frame_end;
			send_led(led, DIR_ROWS[r].typed);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				in_valid <= 1'b0;
				wait_drained();
				// Spare index must leave the period untouched
				if (p % 2 == 0)
					reg_write(SPARE_ADDR, $urandom);
				case (p)
					1: period = 16'd1;
					2: period = 16'hffff;
					3: period = 16'd0;	// outside the range; both high times drop to zero
					4: period = 16'd25;
					5: period = PERIOD_RESET;
					default: period = 16'($urandom_range(1, 65535));
				endcase
				// Drive junk into the upper bits; only the low 16 count
				reg_write(PERIOD_ADDR, {16'($urandom), period});
			end
			// Mostly well-formed frames, with a few stray frame end marks
			sent = 0;
			while (sent < LEDS_PER_PHASE) begin
				frame_len = $urandom_range(1, 12);
				for (int k = 0; k < frame_len && sent < LEDS_PER_PHASE; k++) begin
					led.red = rand_byte();
					led.green = rand_byte();
					led.blue = rand_byte();
					led.last_led = (k == frame_len - 1);
					if ($urandom_range(0, 9) == 0)
						led.last_led = 1'($urandom_range(0, 1));
					send_led(led, 1'b0);
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_slots.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin : watchdog
		#10_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lspbe_pkg.sv
hw/rtl/lspbe_cfg.sv
hw/rtl/lspbe_queue.sv
hw/rtl/lspbe_back.sv
hw/rtl/led_strip_pwm_bit_encoder.sv
tb/testbench.sv
